FILE: design/rft_pkg.sv
package rft_pkg;

  localparam int unsigned MaxLenDefault = 64;
  localparam int unsigned RowsWidth     = 7;
  localparam int unsigned ByteWidth     = 8;
  localparam int unsigned PaddrWidth    = 3;
  localparam int unsigned PdataWidth    = 32;

  localparam logic [0:0] RegNumRows = 1'b0;
  localparam logic [RowsWidth-1:0] NumRowsReset = RowsWidth'(1);

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_READ,
    ST_SHOW
  } rft_state_e;

  typedef struct packed {
    logic load;
    logic start;
    logic step;
    logic done;
  } rft_cmd_t;

  typedef struct packed {
    logic out_last;
  } rft_stat_t;

endpackage

FILE: design/rft_if.sv
interface rft_in_if;
  import rft_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [ByteWidth-1:0] in_byte;
  logic                 in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface rft_out_if;
  import rft_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [ByteWidth-1:0] out_byte;
  logic                 out_last;

  modport source (output valid, output out_byte, output out_last, input ready);
  modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

FILE: design/rft_ctrl.sv
module rft_ctrl import rft_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_last_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  input  rft_stat_t stat_i,
  output rft_cmd_t  cmd_o
);

  rft_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    cmd_o       = '0;
    case (state_q)
      ST_LOAD: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (in_last_i) begin
            cmd_o.start = 1'b1;
            state_d     = ST_READ;
          end
        end
      end
      ST_READ: begin
        cmd_o.step = 1'b1;
        state_d    = ST_SHOW;
      end
      ST_SHOW: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          if (stat_i.out_last) begin
            cmd_o.done = 1'b1;
            state_d    = ST_LOAD;
          end else begin
            state_d = ST_READ;
          end
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

endmodule

FILE: design/rft_dp.sv
module rft_dp import rft_pkg::*; #(
  parameter int unsigned MAX_LEN = MaxLenDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  rft_cmd_t             cmd_i,
  input  logic [RowsWidth-1:0] num_rows_i,
  input  logic [ByteWidth-1:0] in_byte_i,
  output logic [ByteWidth-1:0] out_byte_o,
  output rft_stat_t            stat_o
);

  localparam int unsigned AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int unsigned CW = $clog2(MAX_LEN + 1);
  localparam int unsigned SW = RowsWidth + 2;
  localparam int unsigned NW = ((CW > SW) ? CW : SW) + 1;

  logic [ByteWidth-1:0] mem_q [MAX_LEN];
  logic [ByteWidth-1:0] rd_q;
  logic [CW-1:0]        count_q, count_d;
  logic [CW-1:0]        pos_q, pos_d;
  logic [CW-1:0]        rail_q, rail_d;
  logic [CW-1:0]        sent_q, sent_d;
  logic                 phase_q, phase_d;

  logic                 pass;
  logic [SW-1:0]        rows_w, rail_w, cyc_w, step_w;
  logic [NW-1:0]        next_w;

  assign rows_w = SW'(num_rows_i);
  assign rail_w = SW'(rail_q);
  assign cyc_w  = (rows_w - SW'(1)) << 1;
  assign pass   = (num_rows_i <= RowsWidth'(1)) || (count_q <= CW'(1));

  always_comb begin
    if (pass) begin
      step_w = SW'(1);
    end else if ((rail_q == '0) || (rail_w == rows_w - SW'(1))) begin
      step_w = cyc_w;
    end else if (phase_q) begin
      step_w = rail_w << 1;
    end else begin
      step_w = cyc_w - (rail_w << 1);
    end
  end

  assign next_w = NW'(pos_q) + NW'(step_w);

  always_comb begin
    count_d = count_q;
    pos_d   = pos_q;
    rail_d  = rail_q;
    sent_d  = sent_q;
    phase_d = phase_q;
    if (cmd_i.load && (count_q < CW'(MAX_LEN))) begin
      count_d = count_q + CW'(1);
    end
    if (cmd_i.start) begin
      pos_d   = '0;
      rail_d  = '0;
      sent_d  = '0;
      phase_d = 1'b0;
    end
    if (cmd_i.step) begin
      sent_d = sent_q + CW'(1);
      if (next_w >= NW'(count_q)) begin
        rail_d  = rail_q + CW'(1);
        pos_d   = rail_q + CW'(1);
        phase_d = 1'b0;
      end else begin
        pos_d   = next_w[CW-1:0];
        phase_d = ~phase_q;
      end
    end
    if (cmd_i.done) begin
      count_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      pos_q   <= '0;
      rail_q  <= '0;
      sent_q  <= '0;
      phase_q <= 1'b0;
    end else begin
      count_q <= count_d;
      pos_q   <= pos_d;
      rail_q  <= rail_d;
      sent_q  <= sent_d;
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load && (count_q < CW'(MAX_LEN))) begin
      mem_q[count_q[AW-1:0]] <= in_byte_i;
    end
    if (cmd_i.step) begin
      rd_q <= mem_q[pos_q[AW-1:0]];
    end
  end

  assign out_byte_o      = rd_q;
  assign stat_o.out_last = (sent_q == count_q);

endmodule

FILE: design/rail_fence_transposer.sv
// Channel | Direction | Payload             | Transfer when
// in_ch_i | sink      | in_byte, in_last    | valid & ready
// out_ch_o| source    | out_byte, out_last  | valid & ready
// cfg     | APB slave | num_rows at 0x0     | psel & penable & pwrite
// Loading: one byte per cycle; ready drops after the byte marked last.
// Emission: each output byte is first read from the store into a register, then offered until taken.
// A message is loaded in full before its first byte goes out.
// Reset clears the byte count, the control state and num_rows (to 1).
// A stalled output holds the byte; no new input is taken until the last goes out.
module rail_fence_transposer import rft_pkg::*; #(
  parameter int unsigned MAX_LEN = MaxLenDefault
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  rft_in_if.sink                in_ch_i,
  rft_out_if.source             out_ch_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [PaddrWidth-1:0] paddr,
  input  logic [PdataWidth-1:0] pwdata,
  output logic [PdataWidth-1:0] prdata,
  output logic                  pready
);

  logic [RowsWidth-1:0] num_rows_q;
  rft_cmd_t             cmd;
  rft_stat_t            stat;
  logic                 reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[PaddrWidth-1:2] == RegNumRows);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_rows_q <= NumRowsReset;
    end else if (psel && penable && pwrite && reg_sel) begin
      num_rows_q <= pwdata[RowsWidth-1:0];
    end
  end

  assign prdata = reg_sel ? PdataWidth'(num_rows_q) : '0;

  rft_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_ch_i.valid),
    .in_last_i  (in_ch_i.in_last),
    .in_ready_o (in_ch_i.ready),
    .out_valid_o(out_ch_o.valid),
    .out_ready_i(out_ch_o.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  rft_dp #(
    .MAX_LEN(MAX_LEN)
  ) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .num_rows_i(num_rows_q),
    .in_byte_i (in_ch_i.in_byte),
    .out_byte_o(out_ch_o.out_byte),
    .stat_o    (stat)
  );

  assign out_ch_o.out_last = stat.out_last;

endmodule
